// ----- rtl/cau_pkg.sv -----
// cau_pkg: shared types and constants of the complex arithmetic reduce unit
// holds the operation codes, the queued item type and the default fraction width
// used by cau_front, cau_back and the top level
package cau_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // one classified item as it waits between front and back
  typedef struct packed {
    logic [1:0]         kind;
    logic               reduce;
    logic               first;
    logic               last;
    logic               load;   // reduce run start: accumulator load
    logic               emit;   // this item produces a result beat
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
  } item_t;

endpackage

// ----- rtl/cau_front.sv -----
// cau_front: input side of the complex arithmetic reduce unit
// accepts beats, classifies them and holds them in a two-entry queue
// depends on cau_pkg
module cau_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          kind,
  input  logic                reduce,
  input  logic signed [31:0]  a_re,
  input  logic signed [31:0]  a_im,
  input  logic signed [31:0]  b_re,
  input  logic signed [31:0]  b_im,
  input  logic                first,
  input  logic                last,
  output logic                q_valid,
  input  logic                q_ready,
  output cau_pkg::item_t      q_item
);

  cau_pkg::item_t ent [2];
  cau_pkg::item_t cls;
  logic           wr;
  logic           rd;
  logic [1:0]     cnt;
  logic           do_push;
  logic           do_pop;

  // classify the incoming beat
  always_comb begin
    cls.kind   = kind;
    cls.reduce = reduce;
    cls.first  = first;
    cls.last   = last;
    cls.load   = reduce & first;
    cls.emit   = ~reduce | last;
    cls.a_re   = a_re;
    cls.a_im   = a_im;
    cls.b_re   = b_re;
    cls.b_im   = b_im;
  end

  assign full    = (cnt == 2'd2);
  assign q_valid = (cnt != 2'd0);
  assign q_item  = ent[rd];
  assign do_push = push & ~full;
  assign do_pop  = q_valid & q_ready;

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent[wr] <= cls;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr  <= 1'b0;
      rd  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) begin
        wr <= ~wr;
      end
      if (do_pop) begin
        rd <= ~rd;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 2'd1;
      end else if (!do_push && do_pop) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

endmodule

// ----- rtl/cau_back.sv -----
// cau_back: execution side of the complex arithmetic reduce unit
// shared multiplier, two-lane restoring divider, accumulator and result register
// depends on cau_pkg
module cau_back #(
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  cau_pkg::item_t      item,
  output logic                empty,
  input  logic                pop,
  output logic signed [31:0]  res_re,
  output logic signed [31:0]  res_im,
  output logic                overflow,
  output logic                div_zero
);

  localparam int SH = 33 - FRAC_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_PREP = 3'd3;
  localparam logic [2:0] S_INIT = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0]         state;
  logic [5:0]         cnt;
  logic [1:0]         kind;
  logic               red;
  logic               load;
  logic               emit;
  logic signed [31:0] xr;
  logic signed [31:0] xi;
  logic signed [31:0] yr;
  logic signed [31:0] yi;
  logic signed [63:0] p [6];
  logic signed [64:0] n_re;
  logic signed [64:0] n_im;
  logic [63:0]        den;
  logic [63:0]        mag_re;
  logic [63:0]        mag_im;
  logic               neg_re;
  logic               neg_im;
  logic               den0;
  logic               big_re;
  logic               big_im;
  logic [63:0]        rem_re;
  logic [63:0]        rem_im;
  logic [32:0]        dlo_re;
  logic [32:0]        dlo_im;
  logic [32:0]        q_re;
  logic [32:0]        q_im;
  logic signed [31:0] acc_re;
  logic signed [31:0] acc_im;
  logic               st_ovf;
  logic               st_dz;
  logic               out_valid;

  logic signed [31:0] ma;
  logic signed [31:0] mb;
  logic signed [63:0] prod;
  logic signed [64:0] e [6];
  logic signed [64:0] nn_re;
  logic signed [64:0] nn_im;
  logic [63+SH:0]     wide_mag_re;
  logic [63+SH:0]     wide_mag_im;
  logic [63+SH:0]     wide_den;
  logic [63+FRAC_BITS:0] sh_re;
  logic [63+FRAC_BITS:0] sh_im;
  logic [64:0]        t_re;
  logic [64:0]        t_im;
  logic               ge_re;
  logic               ge_im;
  logic [32:0]        r_re;
  logic [32:0]        r_im;
  logic               f_ovf;
  logic               f_dz;
  logic signed [64:0] s_re;
  logic signed [64:0] s_im;
  logic               fin_go;

  // saturate a wide signed value to 32 bits, overflow flag on top
  function automatic logic [32:0] sat65(input logic signed [64:0] v);
    logic [32:0] r;
    if (!v[64] && (|v[63:31])) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v[64] && !(&v[63:31])) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  // clamp a sign/magnitude quotient
  function automatic logic [32:0] divsat(input logic neg, input logic big,
                                         input logic [32:0] q);
    logic [32:0] r;
    if (!neg) begin
      if (big || q[32] || q[31]) begin
        r = {1'b1, 32'h7FFF_FFFF};
      end else begin
        r = {1'b0, q[31:0]};
      end
    end else begin
      if (big || q[32] || (q[31] && (|q[30:0]))) begin
        r = {1'b1, 32'h8000_0000};
      end else begin
        r = {1'b0, 32'd0 - q[31:0]};
      end
    end
    return r;
  endfunction

  // zero divisor: sign of the dividend part picks the rail, a zero part gives zero
  function automatic logic [31:0] zdp(input logic signed [31:0] v);
    logic [31:0] r;
    if (v[31]) begin
      r = 32'h8000_0000;
    end else if (v != 32'sd0) begin
      r = 32'h7FFF_FFFF;
    end else begin
      r = 32'd0;
    end
    return r;
  endfunction

  assign in_ready = (state == S_IDLE);
  assign empty    = ~out_valid;

  // shared multiplier operand select
  always_comb begin
    case (cnt[2:0])
      3'd0: begin ma = xr; mb = yr; end
      3'd1: begin ma = xi; mb = yi; end
      3'd2: begin ma = xr; mb = yi; end
      3'd3: begin ma = xi; mb = yr; end
      3'd4: begin ma = yr; mb = yr; end
      default: begin ma = yi; mb = yi; end
    endcase
  end
  assign prod = ma * mb;

  // sign-extended products and numerators
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      e[k] = {p[k][63], p[k]};
    end
    nn_re = (kind == cau_pkg::OP_DIV) ? e[0] + e[1] : e[0] - e[1];
    nn_im = (kind == cau_pkg::OP_DIV) ? e[3] - e[2] : e[2] + e[3];
  end

  // divider setup and one restoring step per lane
  always_comb begin
    wide_mag_re = {{SH{1'b0}}, mag_re};
    wide_mag_im = {{SH{1'b0}}, mag_im};
    wide_den    = {den, {SH{1'b0}}};
    sh_re       = {mag_re, {FRAC_BITS{1'b0}}};
    sh_im       = {mag_im, {FRAC_BITS{1'b0}}};
    t_re        = {rem_re, dlo_re[32]};
    t_im        = {rem_im, dlo_im[32]};
    ge_re       = (t_re >= {1'b0, den});
    ge_im       = (t_im >= {1'b0, den});
  end

  // final result of the current operation
  always_comb begin
    s_re  = '0;
    s_im  = '0;
    r_re  = '0;
    r_im  = '0;
    f_dz  = 1'b0;
    case (kind)
      cau_pkg::OP_ADD: begin
        s_re = 65'(xr) + 65'(yr);
        s_im = 65'(xi) + 65'(yi);
        r_re = sat65(s_re);
        r_im = sat65(s_im);
      end
      cau_pkg::OP_SUB: begin
        s_re = 65'(xr) - 65'(yr);
        s_im = 65'(xi) - 65'(yi);
        r_re = sat65(s_re);
        r_im = sat65(s_im);
      end
      cau_pkg::OP_MUL: begin
        r_re = sat65(n_re >>> FRAC_BITS);
        r_im = sat65(n_im >>> FRAC_BITS);
      end
      default: begin
        if (den0) begin
          f_dz = 1'b1;
          r_re = {1'b0, zdp(xr)};
          r_im = {1'b0, zdp(xi)};
        end else begin
          r_re = divsat(neg_re, big_re, q_re);
          r_im = divsat(neg_im, big_im, q_im);
        end
      end
    endcase
    f_ovf = r_re[32] | r_im[32];
  end

  assign fin_go = (state == S_FIN) && (!emit || !out_valid || pop);

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      acc_re    <= '0;
      acc_im    <= '0;
      st_ovf    <= 1'b0;
      st_dz     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid && !(fin_go && emit)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            kind <= item.kind;
            red  <= item.reduce;
            load <= item.load;
            emit <= item.emit;
            cnt  <= '0;
            if (item.reduce && !item.first) begin
              xr <= acc_re;
              xi <= acc_im;
              yr <= item.a_re;
              yi <= item.a_im;
            end else begin
              xr <= item.a_re;
              xi <= item.a_im;
              yr <= item.b_re;
              yi <= item.b_im;
            end
            if (item.load || item.kind == cau_pkg::OP_ADD
                || item.kind == cau_pkg::OP_SUB) begin
              state <= S_FIN;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          p[cnt[2:0]] <= prod;
          cnt <= cnt + 6'd1;
          if ((kind == cau_pkg::OP_DIV && cnt == 6'd5)
              || (kind != cau_pkg::OP_DIV && cnt == 6'd3)) begin
            state <= S_SUM;
          end
        end
        S_SUM: begin
          n_re  <= nn_re;
          n_im  <= nn_im;
          den   <= unsigned'(p[4]) + unsigned'(p[5]);
          state <= (kind == cau_pkg::OP_DIV) ? S_PREP : S_FIN;
        end
        S_PREP: begin
          neg_re <= n_re[64];
          neg_im <= n_im[64];
          mag_re <= n_re[64] ? 64'(-n_re) : n_re[63:0];
          mag_im <= n_im[64] ? 64'(-n_im) : n_im[63:0];
          den0   <= (den == 64'd0);
          state  <= S_INIT;
        end
        S_INIT: begin
          big_re <= (wide_mag_re >= wide_den);
          big_im <= (wide_mag_im >= wide_den);
          rem_re <= mag_re >> SH;
          rem_im <= mag_im >> SH;
          dlo_re <= sh_re[32:0];
          dlo_im <= sh_im[32:0];
          q_re   <= '0;
          q_im   <= '0;
          cnt    <= 6'd32;
          state  <= den0 ? S_FIN : S_DIV;
        end
        S_DIV: begin
          rem_re <= ge_re ? 64'(t_re - {1'b0, den}) : t_re[63:0];
          rem_im <= ge_im ? 64'(t_im - {1'b0, den}) : t_im[63:0];
          q_re   <= {q_re[31:0], ge_re};
          q_im   <= {q_im[31:0], ge_im};
          dlo_re <= {dlo_re[31:0], 1'b0};
          dlo_im <= {dlo_im[31:0], 1'b0};
          cnt    <= cnt - 6'd1;
          if (cnt == 6'd0) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_go) begin
            state <= S_IDLE;
            if (load) begin
              acc_re <= xr;
              acc_im <= xi;
              st_ovf <= 1'b0;
              st_dz  <= 1'b0;
            end else if (red) begin
              acc_re <= r_re[31:0];
              acc_im <= r_im[31:0];
              st_ovf <= st_ovf | f_ovf;
              st_dz  <= st_dz | f_dz;
            end
            if (emit) begin
              out_valid <= 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (fin_go && emit) begin
      if (load) begin
        res_re   <= xr;
        res_im   <= xi;
        overflow <= 1'b0;
        div_zero <= 1'b0;
      end else if (red) begin
        res_re   <= r_re[31:0];
        res_im   <= r_im[31:0];
        overflow <= st_ovf | f_ovf;
        div_zero <= st_dz | f_dz;
      end else begin
        res_re   <= r_re[31:0];
        res_im   <= r_im[31:0];
        overflow <= f_ovf;
        div_zero <= f_dz;
      end
    end
  end

endmodule

// ----- rtl/complex_arith_reduce_unit.sv -----
// complex_arith_reduce_unit: complex add, subtract, multiply and divide on Q pairs
// element-wise or folded over a run; front queue in cau_front, execution in cau_back
// depends on cau_pkg, cau_front, cau_back
//
//   channel  | handshake        | beat
//   ---------+------------------+-------------------------------------------
//   input    | push / full      | kind reduce a_re a_im b_re b_im first last
//   result   | empty / pop      | res_re res_im overflow div_zero
//
// add, subtract and run loads need no multiplier pass; multiply makes four passes
// through the one shared 32x32 multiplier; divide makes six multiplier
// passes, then 33 restoring steps of the two-lane divider (none on zero divisor).
// a two-entry queue takes input beats while the back end is busy or its result
// register waits for pop. reset (rst, synchronous) clears the queue, the
// accumulator and the sticky flags.
module complex_arith_reduce_unit #(
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          kind,
  input  logic                reduce,
  input  logic signed [31:0]  a_re,
  input  logic signed [31:0]  a_im,
  input  logic signed [31:0]  b_re,
  input  logic signed [31:0]  b_im,
  input  logic                first,
  input  logic                last,
  output logic                empty,
  input  logic                pop,
  output logic signed [31:0]  res_re,
  output logic signed [31:0]  res_im,
  output logic                overflow,
  output logic                div_zero
);

  logic           q_valid;
  logic           q_ready;
  cau_pkg::item_t q_item;

  cau_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .kind    (kind),
    .reduce  (reduce),
    .a_re    (a_re),
    .a_im    (a_im),
    .b_re    (b_re),
    .b_im    (b_im),
    .first   (first),
    .last    (last),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item)
  );

  cau_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (q_valid),
    .in_ready (q_ready),
    .item     (q_item),
    .empty    (empty),
    .pop      (pop),
    .res_re   (res_re),
    .res_im   (res_im),
    .overflow (overflow),
    .div_zero (div_zero)
  );

  // back end goes busy right after taking a queued beat
  a_busy: assert property (@(posedge clk) disable iff (rst)
    q_valid && q_ready |=> !q_ready)
    else $error("back end still ready after taking a beat");

  // a waiting result is never dropped without pop
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty)
    else $error("result lost without pop");

  // the queue fills only through an input beat
  a_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(full) |-> $past(push))
    else $error("queue filled without push");

  // a waiting result beat carries known values
  a_known: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !$isunknown({res_re, res_im, overflow, div_zero}))
    else $error("result beat has unknown bits");

endmodule
